FILE: src/sdsvpwm_pkg.sv
// package for the sine drive svpwm block: widths, constants, sine table function
// used by every module in src
package sdsvpwm_pkg;

    localparam int AngleBits     = 16;
    localparam int SineTableBits = 10;
    localparam int QuarterBits   = SineTableBits - 2;
    localparam int InvSqrt3Q16   = 37837;
    localparam int TwoInvSqrt3Q16 = 75674;
    localparam logic [14:0] SupplyReset = 15'd12000;

    localparam logic [2:0] SEC0 = 3'd0;
    localparam logic [2:0] SEC1 = 3'd1;
    localparam logic [2:0] SEC2 = 3'd2;
    localparam logic [2:0] SEC3 = 3'd3;
    localparam logic [2:0] SEC4 = 3'd4;
    localparam logic [2:0] SEC5 = 3'd5;

    typedef logic [SineTableBits-1:0] t_tidx;
    typedef logic [(1 << QuarterBits)-1:0][15:0] t_qtab;

    // quarter-wave sine, q1.15, by fixed-point polynomial; only evaluated to fill the table
    function automatic logic signed [16:0] quarter_sine(input logic [QuarterBits:0] pos);
        logic [63:0] t, s, p, r;
        begin
            t = 64'(pos) << (18 - SineTableBits);
            s = (t * t) >> 16;
            p = 64'd172272;
            p = 64'd5026995 - ((p * s) >> 16);
            p = 64'd85569306 - ((p * s) >> 16);
            p = 64'd693598678 - ((p * s) >> 16);
            p = 64'd1686629713 - ((p * s) >> 16);
            r = (p * t + (64'd1 << 30)) >> 31;
            if (r > 64'd32767) r = 64'd32767;
            quarter_sine = 17'(r);
        end
    endfunction

    function automatic t_qtab build_qtab();
        t_qtab tab;
        begin
            for (int i = 0; i < (1 << QuarterBits); i++)
                tab[i] = 16'(quarter_sine((QuarterBits+1)'(i)));
            build_qtab = tab;
        end
    endfunction

    // constant quarter table, plus the entry at exactly ninety degrees
    localparam t_qtab QuarterTab = build_qtab();
    localparam logic signed [16:0] QuarterTop =
        quarter_sine((QuarterBits+1)'(1) << QuarterBits);

    function automatic logic signed [16:0] table_sine(input t_tidx k);
        logic [1:0] q;
        logic [QuarterBits:0] x, pos;
        logic signed [16:0] v;
        begin
            q   = k[SineTableBits-1 -: 2];
            x   = {1'b0, k[QuarterBits-1:0]};
            pos = q[0] ? ((QuarterBits+1)'(1) << QuarterBits) - x : x;
            if (pos[QuarterBits]) v = QuarterTop;
            else v = 17'(QuarterTab[pos[QuarterBits-1:0]]);
            table_sine = q[1] ? -v : v;
        end
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [23:0] v);
        if (v > 24'sd32767) sat16 = 16'sh7fff;
        else if (v < -24'sd32768) sat16 = 16'sh8000;
        else sat16 = v[15:0];
    endfunction

    typedef struct packed {
        logic [15:0] pu;
        logic [15:0] pv;
        logic [15:0] pw;
        logic [2:0]  sec;
        logic [15:0] idm;
        logic [15:0] iqm;
    } t_result;

endpackage

FILE: src/sine_drive_svpwm_with_dq_measure_unit.sv
// channel   | tdata fields (lsb first)                        | width
// s_axis    | elec_angle, vd_ref, vq_ref, current_u/v/w       | 96
// m_axis    | phase_u/v/w_volt, sector, id_meas, iq_meas       | 88
// cfg       | supply_voltage                                  | 15
// eight register stages; one beat per cycle while the output beat is not held
// the whole pipe stalls when the output beat is held; nothing is lost
// reset is synchronous and clears valids; supply_voltage returns to 12000
module sine_drive_svpwm_with_dq_measure_unit
    import sdsvpwm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [95:0] s_axis_tdata,  // elec_angle, vd_ref, vq_ref, current_u, current_v, current_w
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [87:0] m_axis_tdata,  // phase_u, phase_v, phase_w, sector, id_meas, iq_meas, pad
    input  logic        i_cfg_we,
    input  logic [14:0] i_cfg_wdata
);
    logic [14:0] r_vm;
    logic en;
    t_result res;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vm <= SupplyReset;
        else if (i_cfg_we) r_vm <= i_cfg_wdata;
    end
    sdsvpwm_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_valid(s_axis_tvalid), .i_ready(m_axis_tready),
        .o_en(en), .o_ready(s_axis_tready), .o_valid(m_axis_tvalid)
    );
    sdsvpwm_core u_core (
        .i_clk, .i_en(en),
        .i_angle(s_axis_tdata[15:0]), .i_vd(s_axis_tdata[31:16]),
        .i_vq(s_axis_tdata[47:32]), .i_iu(s_axis_tdata[63:48]),
        .i_iv(s_axis_tdata[79:64]), .i_iw(s_axis_tdata[95:80]),
        .i_vm(r_vm), .o_res(res)
    );
    assign m_axis_tdata = {5'd0, res.iqm, res.idm, res.sec, res.pw, res.pv, res.pu};
endmodule

FILE: src/sdsvpwm_core.sv
// datapath pipeline: inverse park, sector, svpwm phases, clarke and park
// depends on sdsvpwm_pkg; advances when i_en is high
module sdsvpwm_core
    import sdsvpwm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [15:0] i_angle,
    input  logic signed [15:0] i_vd,
    input  logic signed [15:0] i_vq,
    input  logic signed [15:0] i_iu,
    input  logic signed [15:0] i_iv,
    input  logic signed [15:0] i_iw,
    input  logic [14:0] i_vm,
    output t_result     o_res
);
    // stage 1: table lookup
    logic signed [16:0] r1_sn, r1_cs;
    logic signed [15:0] r1_vd, r1_vq, r1_iu, r1_iv, r1_iw;
    t_tidx idx;
    logic [AngleBits-1:0] ang;
    assign ang = i_angle[AngleBits-1:0];
    if (AngleBits >= SineTableBits) begin : g_idx_tr
        assign idx = ang[AngleBits-1 -: SineTableBits];
    end else begin : g_idx_pad
        assign idx = {ang, {(SineTableBits-AngleBits){1'b0}}};
    end
    t_tidx idx_c;
    assign idx_c = idx + (t_tidx'(1) << QuarterBits);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_sn <= table_sine(idx);
            r1_cs <= table_sine(idx_c);
            r1_vd <= i_vd; r1_vq <= i_vq;
            r1_iu <= i_iu; r1_iv <= i_iv; r1_iw <= i_iw;
        end
    end

    // stage 2: products
    logic signed [33:0] r2_vdc, r2_vqs, r2_vds, r2_vqc;
    logic signed [16:0] r2_sn, r2_cs;
    logic signed [15:0] r2_iu, r2_iv, r2_iw;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_vdc <= 34'(r1_vd * r1_cs);
            r2_vqs <= 34'(r1_vq * r1_sn);
            r2_vds <= 34'(r1_vd * r1_sn);
            r2_vqc <= 34'(r1_vq * r1_cs);
            r2_sn <= r1_sn; r2_cs <= r1_cs;
            r2_iu <= r1_iu; r2_iv <= r1_iv; r2_iw <= r1_iw;
        end
    end

    // stage 3: alpha/beta
    logic signed [34:0] n_sa, n_sb;
    assign n_sa = 35'(r2_vdc) - 35'(r2_vqs) + 35'sd16384;
    assign n_sb = 35'(r2_vds) + 35'(r2_vqc) + 35'sd16384;
    logic signed [17:0] r3_va, r3_vb;
    logic signed [16:0] r3_sn, r3_cs;
    logic signed [15:0] r3_iu, r3_iv, r3_iw;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_va <= 18'(n_sa >>> 15);
            r3_vb <= 18'(n_sb >>> 15);
            r3_sn <= r2_sn; r3_cs <= r2_cs;
            r3_iu <= r2_iu; r3_iv <= r2_iv; r3_iw <= r2_iw;
        end
    end

    // stage 4: squares for sector test, vb scaling
    logic signed [36:0] r4_a2, r4_b2;
    logic signed [35:0] r4_b1p, r4_b2p;
    logic signed [17:0] r4_va, r4_vb;
    logic signed [16:0] r4_sn, r4_cs;
    logic signed [15:0] r4_iu, r4_iv, r4_iw;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_a2  <= 37'(3 * 37'(r3_va) * 37'(r3_va));
            r4_b2  <= 37'(37'(r3_vb) * 37'(r3_vb));
            r4_b1p <= 36'(36'(r3_vb) * 36'sd37837);
            r4_b2p <= 36'(36'(r3_vb) * 36'sd75674);
            r4_va <= r3_va; r4_vb <= r3_vb;
            r4_sn <= r3_sn; r4_cs <= r3_cs;
            r4_iu <= r3_iu; r4_iv <= r3_iv; r4_iw <= r3_iw;
        end
    end

    // stage 5: sector, v1/v2, clarke beta product
    function automatic int sgn(input logic signed [17:0] a, input logic signed [17:0] b,
                               input logic signed [37:0] d);
        int s;
        begin
            s = (d > 0) ? 1 : ((d < 0) ? -1 : 0);
            if (a == 0 && b == 0) sgn = 0;
            else if (a >= 0 && b <= 0) sgn = 1;
            else if (a <= 0 && b >= 0) sgn = -1;
            else sgn = (a > 0) ? s : -s;
        end
    endfunction
    logic signed [37:0] dd;
    assign dd = 38'(r4_a2) - 38'(r4_b2);
    int p, m;
    logic [2:0] sec;
    logic signed [17:0] nvb;
    assign nvb = -r4_vb;
    assign p = sgn(r4_va, r4_vb, dd);
    assign m = sgn(r4_va, nvb, dd);
    always_comb begin
        if (r4_vb >= 0)
            sec = (r4_va == 0 && r4_vb == 0) ? SEC0 : (p > 0 ? SEC0 : (m > 0 ? SEC1 : SEC2));
        else
            sec = (p < 0) ? SEC3 : (m < 0 ? SEC4 : SEC5);
    end
    logic signed [19:0] b1, b2;
    assign b1 = 20'((r4_b1p + 36'sd32768) >>> 16);
    assign b2 = 20'((r4_b2p + 36'sd32768) >>> 16);
    logic signed [21:0] v1, v2;
    logic signed [17:0] ia;
    logic signed [18:0] cb;
    always_comb begin
        case (sec)
            SEC3: begin v1 = 22'(-r4_va) + 22'(b1); v2 = -22'(b2); end
            SEC4: begin v1 = 22'(-r4_va) - 22'(b1); v2 = 22'(r4_va) - 22'(b1); end
            SEC5: begin v1 = 22'(r4_va) + 22'(b1); v2 = -22'(b2); end
            SEC0: begin v1 = 22'(r4_va) - 22'(b1); v2 = 22'(b2); end
            SEC1: begin v1 = 22'(r4_va) + 22'(b1); v2 = 22'(-r4_va) + 22'(b1); end
            default: begin v1 = 22'(b2); v2 = 22'(-r4_va) - 22'(b1); end
        endcase
        if (sec == SEC3 || sec == SEC4) begin
            ia = 18'(r4_iu);
            cb = 19'(r4_iu) + 19'(r4_iv) + 19'(r4_iv);
        end else if (sec == SEC5 || sec == SEC0) begin
            ia = -(18'(r4_iv) + 18'(r4_iw));
            cb = 19'(r4_iv) - 19'(r4_iw);
        end else begin
            ia = 18'(r4_iu);
            cb = -(19'(r4_iu) + 19'(r4_iw) + 19'(r4_iw));
        end
    end
    logic signed [21:0] r5_v1, r5_v2;
    logic [2:0] r5_sec;
    logic signed [17:0] r5_ia;
    logic signed [36:0] r5_cbp;
    logic signed [16:0] r5_sn, r5_cs;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r5_v1 <= v1; r5_v2 <= v2; r5_sec <= sec; r5_ia <= ia;
            r5_cbp <= 37'(37'(cb) * 37'sd37837);
            r5_sn <= r4_sn; r5_cs <= r4_cs;
        end
    end

    // stage 6: centring term, clarke beta rounding
    logic signed [22:0] v3s;
    assign v3s = 23'(i_vm) - 23'(r5_v1) - 23'(r5_v2) + 23'sd1;
    logic signed [21:0] r6_v1, r6_v2, r6_v3;
    logic [2:0] r6_sec;
    logic signed [17:0] r6_ia;
    logic signed [20:0] r6_ib;
    logic signed [16:0] r6_sn, r6_cs;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r6_v3 <= 22'(v3s >>> 1);
            r6_v1 <= r5_v1; r6_v2 <= r5_v2; r6_sec <= r5_sec; r6_ia <= r5_ia;
            r6_ib <= 21'((r5_cbp + 37'sd32768) >>> 16);
            r6_sn <= r5_sn; r6_cs <= r5_cs;
        end
    end

    // stage 7: phases and park products
    logic signed [23:0] pu, pv, pw, s12;
    assign s12 = 24'(r6_v1) + 24'(r6_v2) + 24'(r6_v3);
    always_comb begin
        case (r6_sec)
            SEC3: begin pu = 24'(r6_v3); pv = 24'(r6_v1) + 24'(r6_v3); pw = s12; end
            SEC4: begin pu = 24'(r6_v2) + 24'(r6_v3); pv = 24'(r6_v3); pw = s12; end
            SEC5: begin pu = s12; pv = 24'(r6_v3); pw = 24'(r6_v2) + 24'(r6_v3); end
            SEC0: begin pu = s12; pv = 24'(r6_v2) + 24'(r6_v3); pw = 24'(r6_v3); end
            SEC1: begin pu = 24'(r6_v1) + 24'(r6_v3); pv = s12; pw = 24'(r6_v3); end
            default: begin pu = 24'(r6_v3); pv = s12; pw = 24'(r6_v2) + 24'(r6_v3); end
        endcase
    end
    logic signed [15:0] r7_pu, r7_pv, r7_pw;
    logic [2:0] r7_sec;
    logic signed [37:0] r7_ac, r7_bs, r7_bc, r7_as;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r7_pu <= sat16(pu); r7_pv <= sat16(pv); r7_pw <= sat16(pw);
            r7_sec <= r6_sec;
            r7_ac <= 38'(r6_ia * r6_cs);
            r7_as <= 38'(r6_ia * r6_sn);
            r7_bc <= 38'(r6_ib * r6_cs);
            r7_bs <= 38'(r6_ib * r6_sn);
        end
    end

    // stage 8: id/iq
    logic signed [38:0] sd, sq;
    logic signed [23:0] idm, iqm;
    assign sd = 39'(r7_ac) + 39'(r7_bs) + 39'sd16384;
    assign sq = 39'(r7_bc) - 39'(r7_as) + 39'sd16384;
    always_comb begin
        idm = (sd >>> 15) > 39'sd32767 ? 24'sd32767 :
              ((sd >>> 15) < -39'sd32768 ? -24'sd32768 : 24'(sd >>> 15));
        iqm = (sq >>> 15) > 39'sd32767 ? 24'sd32767 :
              ((sq >>> 15) < -39'sd32768 ? -24'sd32768 : 24'(sq >>> 15));
    end
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_res.pu  <= r7_pu;
            o_res.pv  <= r7_pv;
            o_res.pw  <= r7_pw;
            o_res.sec <= r7_sec;
            o_res.idm <= sat16(idm);
            o_res.iqm <= sat16(iqm);
        end
    end
endmodule

FILE: src/sdsvpwm_ctrl.sv
// valid pipeline control for the datapath, one valid bit per stage
// depends on sdsvpwm_pkg
module sdsvpwm_ctrl
    import sdsvpwm_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  logic i_ready,
    output logic o_en,
    output logic o_ready,
    output logic o_valid
);
    localparam int Depth = 8;
    logic [Depth-1:0] r_vld, n_vld;
    // whole pipe moves when the output end is free
    assign o_en    = !r_vld[Depth-1] || i_ready;
    assign o_ready = o_en;
    assign o_valid = r_vld[Depth-1];
    assign n_vld   = {r_vld[Depth-2:0], i_valid};
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (o_en) begin
            r_vld <= n_vld;
        end
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid) else $error("result dropped in stall");
    a_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_en && i_valid |=> r_vld[0]) else $error("beat lost at entry");
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_en |=> $stable(r_vld)) else $error("valid moved in stall");
endmodule

FILE: bench/sdsvpwm_checker.sv
// checker for the sine drive svpwm unit: watches both stream channels and the
// config port, predicts each result beat and compares; depends on sdsvpwm_pkg
module sdsvpwm_checker
    import sdsvpwm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [95:0] s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [87:0] m_axis_tdata,
    input  logic        i_cfg_we,
    input  logic [14:0] i_cfg_wdata,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [15:0] pu, pv, pw;
        logic [2:0]  sec;
        logic [15:0] idm, iqm;
    } t_svm_out;

    t_svm_out    svm_expected[$];
    logic [14:0] bus_mv;
    int          fails = 0;

    assign o_fail_count = fails;
    assign o_pending    = svm_expected.size();

    function automatic longint fdiv(longint v, int n);
        longint q;
        q = v >>> n;
        return q;
    endfunction

    function automatic longint rnd(longint v, int n);
        return fdiv(v + (longint'(1) << (n - 1)), n);
    endfunction

    function automatic logic [15:0] clip16(longint v);
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v[15:0];
    endfunction

    function automatic longint sine_q15(longint k);
        longint quarter, q, x, pos, t, s, p, r;
        quarter = 1 << (SineTableBits - 2);
        k = k & ((1 << SineTableBits) - 1);
        q = (k >> (SineTableBits - 2)) & 3;
        x = k & (quarter - 1);
        pos = q[0] ? quarter - x : x;
        t = pos << (18 - SineTableBits);
        s = (t * t) >> 16;
        p = 172272;
        p = 5026995 - ((p * s) >> 16);
        p = 85569306 - ((p * s) >> 16);
        p = 693598678 - ((p * s) >> 16);
        p = 1686629713 - ((p * s) >> 16);
        r = (p * t + (longint'(1) << 30)) >> 31;
        if (r > 32767) r = 32767;
        return q[1] ? -r : r;
    endfunction

    // sign of sqrt3*a - b without irrationals
    function automatic int r3_sign(longint a, longint b);
        longint d;
        int sg;
        if (a == 0 && b == 0) return 0;
        if (a >= 0 && b <= 0) return 1;
        if (a <= 0 && b >= 0) return -1;
        d = 3 * a * a - b * b;
        sg = (d > 0) ? 1 : ((d < 0) ? -1 : 0);
        return (a > 0) ? sg : -sg;
    endfunction

    function automatic t_svm_out svm_predict(logic [95:0] d, logic [14:0] vbus);
        t_svm_out o;
        longint idx, vd, vq, iu, iv, iw, sn, cs, va, vb, b1, b2;
        longint v1, v2, v3, pu, pv, pw, ia, ib;
        int p, m;
        logic [2:0] sec;
        idx = longint'(d[15:0]) >> (AngleBits - SineTableBits);
        vd = longint'($signed(d[31:16]));
        vq = longint'($signed(d[47:32]));
        iu = longint'($signed(d[63:48]));
        iv = longint'($signed(d[79:64]));
        iw = longint'($signed(d[95:80]));
        sn = sine_q15(idx);
        cs = sine_q15(idx + (1 << (SineTableBits - 2)));
        va = rnd(vd * cs - vq * sn, 15);
        vb = rnd(vd * sn + vq * cs, 15);
        b1 = rnd(vb * InvSqrt3Q16, 16);
        b2 = rnd(vb * TwoInvSqrt3Q16, 16);
        p = r3_sign(va, vb);
        m = r3_sign(va, -vb);
        if (vb >= 0)
            sec = (va == 0 && vb == 0) ? SEC0 : (p > 0 ? SEC0 : (m > 0 ? SEC1 : SEC2));
        else
            sec = (p < 0) ? SEC3 : (m < 0 ? SEC4 : SEC5);
        case (sec)
            SEC3: begin v1 = -va + b1; v2 = -b2; end
            SEC4: begin v1 = -va - b1; v2 = va - b1; end
            SEC5: begin v1 = va + b1; v2 = -b2; end
            SEC0: begin v1 = va - b1; v2 = b2; end
            SEC1: begin v1 = va + b1; v2 = -va + b1; end
            default: begin v1 = b2; v2 = -va - b1; end
        endcase
        v3 = rnd(longint'(vbus) - v1 - v2, 1);
        case (sec)
            SEC3: begin pu = v3; pv = v1 + v3; pw = v1 + v2 + v3; end
            SEC4: begin pu = v2 + v3; pv = v3; pw = v1 + v2 + v3; end
            SEC5: begin pu = v1 + v2 + v3; pv = v3; pw = v2 + v3; end
            SEC0: begin pu = v1 + v2 + v3; pv = v2 + v3; pw = v3; end
            SEC1: begin pu = v1 + v3; pv = v1 + v2 + v3; pw = v3; end
            default: begin pu = v3; pv = v1 + v2 + v3; pw = v2 + v3; end
        endcase
        // clarke picks the two currents that suit the sector
        if (sec == SEC3 || sec == SEC4) begin
            ia = iu;
            ib = rnd((iu + 2 * iv) * InvSqrt3Q16, 16);
        end else if (sec == SEC5 || sec == SEC0) begin
            ia = -(iv + iw);
            ib = rnd((iv - iw) * InvSqrt3Q16, 16);
        end else begin
            ia = iu;
            ib = rnd(-(iu + 2 * iw) * InvSqrt3Q16, 16);
        end
        o.pu = clip16(pu);
        o.pv = clip16(pv);
        o.pw = clip16(pw);
        o.sec = sec;
        o.idm = clip16(rnd(ia * cs + ib * sn, 15));
        o.iqm = clip16(rnd(ib * cs - ia * sn, 15));
        return o;
    endfunction

    task automatic check_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
        if (exp_v !== act_v) begin
            fails++;
            $display("%0t mismatch %s expected %0d actual %0d", $time, name,
                     $signed(exp_v), $signed(act_v));
        end
    endtask

    always @(posedge i_clk) begin
        t_svm_out e;
        if (!i_rst_n) begin
            bus_mv <= SupplyReset;
        end else begin
            if (i_cfg_we) bus_mv <= i_cfg_wdata;
            if (s_axis_tvalid && s_axis_tready)
                svm_expected.push_back(svm_predict(s_axis_tdata, bus_mv));
            if (m_axis_tvalid && m_axis_tready) begin
                if (svm_expected.size() == 0) begin
                    fails++;
                    $display("%0t unexpected result beat %h", $time, m_axis_tdata);
                end else begin
                    e = svm_expected.pop_front();
                    check_field("phase_u", e.pu, m_axis_tdata[15:0]);
                    check_field("phase_v", e.pv, m_axis_tdata[31:16]);
                    check_field("phase_w", e.pw, m_axis_tdata[47:32]);
                    check_field("sector", 16'(e.sec), 16'(m_axis_tdata[50:48]));
                    check_field("id_meas", e.idm, m_axis_tdata[66:51]);
                    check_field("iq_meas", e.iqm, m_axis_tdata[82:67]);
                end
            end
        end
    end
endmodule

FILE: bench/tb_sine_drive_svpwm_with_dq_measure_unit.sv
// stimulus and verdict for the sine drive svpwm unit
// depends on sdsvpwm_pkg, the unit and bench/sdsvpwm_checker.sv
module tb_sine_drive_svpwm_with_dq_measure_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import sdsvpwm_pkg::*;

    localparam int CycleLimit = 400000;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [95:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [87:0] m_axis_tdata;
    logic        i_cfg_we = 0;
    logic [14:0] i_cfg_wdata = '0;
    int          fail_count, pending;
    int          cycles = 0;
    int          hold_off = 0;
    bit          hold_req = 0;
    bit          hold_done = 0;
    bit          stall_on = 0;

    sine_drive_svpwm_with_dq_measure_unit uut (.*);

    sdsvpwm_checker chk (
        .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .i_cfg_we, .i_cfg_wdata,
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // receiver: a long hold-off when asked, else always ready, or a random stall pattern with stall_on
    always @(posedge i_clk) begin
        if (hold_req && !hold_done) begin
            hold_done     <= 1'b1;
            hold_off      <= 60;
            m_axis_tready <= 1'b0;
        end else if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_axis_tready <= 1'b0;
        end else if (!stall_on) begin
            m_axis_tready <= 1'b1;
        end else begin
            m_axis_tready <= ($urandom_range(0, 3) != 0);
        end
    end

    function automatic logic [15:0] pick16();
        case ($urandom_range(0, 5))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'($signed($urandom_range(0, 4000)) - 2000);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_beat(logic [95:0] d);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task automatic gap(int n);
        s_axis_tvalid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic random_burst_phase(int count);
        int left;
        left = count;
        while (left > 0) begin
            for (int b = $urandom_range(1, 20); b > 0 && left > 0; b--) begin
                send_beat({pick16(), pick16(), pick16(), pick16(), pick16(),
                           16'($urandom)});
                left--;
            end
            if ($urandom_range(0, 2) != 0) gap($urandom_range(1, 6));
        end
        gap(0);
    endtask

    // wait for the pipe to drain before touching the supply register
    task automatic drain_and_write(logic [14:0] v);
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    logic [15:0] angles[6] = '{16'h0000, 16'h4000, 16'h8000, 16'hc000, 16'hffff, 16'h1555};

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // directed: zero vector, field extremes and every sector
        send_beat('0);
        foreach (angles[k]) begin
            send_beat({16'h7fff, 16'h8000, 16'h7fff, 16'd0, 16'd0, angles[k]});
            send_beat({16'h8000, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff, angles[k]});
        end
        for (int s = 0; s < 12; s++)
            send_beat({16'd300, 16'd200, 16'd100, 16'd0, 16'd1000, 16'(s * 5461)});
        // beta zero with alpha negative
        send_beat({16'd0, 16'd0, 16'd0, 16'd0, 16'h8000, 16'h0000});
        drain_and_write(15'd0);
        stall_on <= 1'b1;
        random_burst_phase(250);
        drain_and_write(15'h7fff);
        hold_req <= 1'b1;
        random_burst_phase(250);
        drain_and_write(15'($urandom));
        stall_on <= 1'b0;
        random_burst_phase(250);
        drain_and_write(15'd24000);
        stall_on <= 1'b1;
        random_burst_phase(280);
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule

FILE: sim.f
src/sdsvpwm_pkg.sv
src/sdsvpwm_core.sv
src/sdsvpwm_ctrl.sv
src/sine_drive_svpwm_with_dq_measure_unit.sv
bench/sdsvpwm_checker.sv
bench/tb_sine_drive_svpwm_with_dq_measure_unit.sv
